@@ src/cesd_pkg.sv @@
package cesd_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_HEX  = 4'b0100,
        MODE_CR   = 4'b1000
    } mode_t;

    localparam logic [1:0] CFG_DELIMITER = 2'd0;
    localparam logic [1:0] CFG_ESCAPE    = 2'd1;
    localparam logic [1:0] CFG_ENABLE    = 2'd2;

    localparam logic [7:0] DELIMITER_RESET = 8'd34;
    localparam logic [7:0] ESCAPE_RESET    = 8'd92;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_N   = 8'h6e;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CH_X   = 8'h78;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // Up to two results produced by one accepted request.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic    emit;
        logic    to_esc;
        result_t res;
    } idle_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.value = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: h.value = c[3:0] + 4'd9;
            default:       h.valid = 1'b0;
        endcase
        return h;
    endfunction

    function automatic result_t make_result(input kind_t kind, input logic [7:0] data);
        result_t r;
        r.kind = kind;
        r.data = (kind == KIND_BYTE) ? data : 8'd0;
        r.last = 1'b0;
        return r;
    endfunction

    // Handling of a byte outside any escape sequence.
    function automatic idle_t idle_step(input logic [7:0] c, input logic eoi,
                                        input logic [7:0] delim, input logic [7:0] esc,
                                        input logic enabled);
        idle_t s;
        s.emit   = 1'b1;
        s.to_esc = 1'b0;
        if (eoi)
            s.res = make_result(KIND_ERROR, 8'd0);
        else if (c == delim)
            s.res = make_result(KIND_CLOSED, 8'd0);
        else if (c == CH_NUL || c == CH_LF)
            s.res = make_result(KIND_ERROR, 8'd0);
        else if (c == esc && enabled)
        begin
            s.emit   = 1'b0;
            s.to_esc = 1'b1;
            s.res    = make_result(KIND_BYTE, 8'd0);
        end
        else
            s.res = make_result(KIND_BYTE, c);
        return s;
    endfunction

endpackage

@@ src/cesd_if.sv @@
interface cesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface cesd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] decoded_byte;
    logic       last_of_run;

    modport source (output valid, output result_kind, output decoded_byte,
                    output last_of_run, input ready);
    modport sink (input valid, input result_kind, input decoded_byte,
                  input last_of_run, output ready);
endinterface

@@ src/cesd_core.sv @@
module cesd_core
    import cesd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] source_byte,
    input  logic       end_of_input,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output push_t      push
);

    logic [7:0] delim_reg;
    logic [7:0] esc_reg;
    logic       enable_reg;
    mode_t      mode_reg, mode_next;
    logic       hex_cnt_reg, hex_cnt_next;
    logic [7:0] hex_acc_reg, hex_acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= DELIMITER_RESET;
            esc_reg    <= ESCAPE_RESET;
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELIMITER: delim_reg  <= cfg_data;
                CFG_ESCAPE:    esc_reg    <= cfg_data;
                CFG_ENABLE:    enable_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 1'b0;
            hex_acc_reg <= 8'd0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
        end
    end

    idle_t      idle;
    hex_t       digit;
    logic [7:0] acc_shift;
    result_t    r0, r1;
    logic [1:0] n;

    assign idle      = idle_step(source_byte, end_of_input, delim_reg, esc_reg, enable_reg);
    assign digit     = hex_value(source_byte);
    assign acc_shift = {hex_acc_reg[3:0], digit.value};

    always_comb
    begin
        mode_next    = MODE_IDLE;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        r0           = make_result(KIND_BYTE, 8'd0);
        r1           = make_result(KIND_BYTE, 8'd0);
        n            = 2'd0;
        case (mode_reg)
            MODE_IDLE:
            begin
                r0        = idle.res;
                n         = {1'b0, idle.emit};
                mode_next = idle.to_esc ? MODE_ESC : MODE_IDLE;
            end
            MODE_ESC:
            begin
                n = 2'd1;
                if (end_of_input)
                    r0 = make_result(KIND_CLOSED, 8'd0);
                else
                begin
                    case (source_byte)
                        CH_A:    r0 = make_result(KIND_BYTE, CODE_BEL);
                        CH_B:    r0 = make_result(KIND_BYTE, CODE_BS);
                        CH_V:    r0 = make_result(KIND_BYTE, CODE_VT);
                        CH_T:    r0 = make_result(KIND_BYTE, CODE_HT);
                        CH_N:    r0 = make_result(KIND_BYTE, CODE_LF);
                        CH_F:    r0 = make_result(KIND_BYTE, CODE_FF);
                        CH_R:    r0 = make_result(KIND_BYTE, CODE_CR);
                        CH_X:
                        begin
                            n            = 2'd0;
                            mode_next    = MODE_HEX;
                            hex_cnt_next = 1'b0;
                            hex_acc_next = 8'd0;
                        end
                        CH_CR:
                        begin
                            n         = 2'd0;
                            mode_next = MODE_CR;
                        end
                        CH_LF:   n  = 2'd0;
                        default: r0 = make_result(KIND_BYTE, source_byte);
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (!end_of_input && digit.valid)
                begin
                    if (hex_cnt_reg)
                    begin
                        r0           = make_result(KIND_BYTE, acc_shift);
                        n            = 2'd1;
                        hex_cnt_next = 1'b0;
                        hex_acc_next = 8'd0;
                    end
                    else
                    begin
                        mode_next    = MODE_HEX;
                        hex_cnt_next = 1'b1;
                        hex_acc_next = acc_shift;
                    end
                end
                else
                begin
                    // The escape ends early and the terminator is decoded as a fresh byte.
                    r0           = make_result(KIND_BYTE, hex_cnt_reg ? hex_acc_reg : CH_X);
                    r1           = idle.res;
                    n            = idle.emit ? 2'd2 : 2'd1;
                    mode_next    = idle.to_esc ? MODE_ESC : MODE_IDLE;
                    hex_cnt_next = 1'b0;
                    hex_acc_next = 8'd0;
                end
            end
            MODE_CR:
            begin
                if (end_of_input)
                begin
                    r0 = make_result(KIND_ERROR, 8'd0);
                    n  = 2'd1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
        r0.last = (n == 2'd1);
        r1.last = (n == 2'd2);
    end

    assign push.count  = fire ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

endmodule

@@ src/cesd_outq.sv @@
module cesd_outq
    import cesd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space,
    output logic    valid,
    input  logic    ready,
    output result_t head
);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    assign pop          = valid && ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
    assign count_next   = count_reg + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    // A request may add two results, so room for two is needed to take one.
    assign space = (count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

endmodule

@@ src/c_escape_sequence_decoder.sv @@
// Decodes the body of a quoted literal with C-style escapes, one source byte per request.
// Requests are taken at one per clock while the output queue has room; their results are
// written into it and offered no earlier than the cycle after acceptance. A hex escape cut
// short by a non-hex byte other than the escape byte yields two results, one more than the
// output hands out in a cycle. The four-entry output queue takes a request only while it
// has room for two results, so the input is held back whenever three or more results are
// waiting. These extra results pile up only while no request that yields nothing comes
// along to let the queue drain, and output stalls hold the input back in the same way.
// Each run of results ends with last_of_run set; a request that yields nothing (escape
// byte, first hex digit, line continuation) produces no result at all. Configuration writes
// are taken at any time but are meant to be issued only while the block is idle.
module c_escape_sequence_decoder
    import cesd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cesd_in_if.sink    in_ch,
    cesd_out_if.source out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic    fire;
    logic    space;
    push_t   push;
    result_t head;

    assign in_ch.ready = space;
    assign fire        = in_ch.valid && space;

    cesd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .source_byte  (in_ch.source_byte),
        .end_of_input (in_ch.end_of_input),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push)
    );

    cesd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .valid (out_ch.valid),
        .ready (out_ch.ready),
        .head  (head)
    );

    assign out_ch.result_kind  = head.kind;
    assign out_ch.decoded_byte = head.data;
    assign out_ch.last_of_run  = head.last;

endmodule
